// ----- design/wcv_pkg.sv -----
// Shared types, constants and helpers for the 2D window convolution block.
// No dependencies; wcv_front, wcv_back and the top level import this package.
package wcv_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int STORE_ROWS = MAX_KERNEL + 1;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SROW_W  = $clog2(STORE_ROWS);
  localparam int LDEPTH  = STORE_ROWS * MAX_WIDTH;
  localparam int LADDR_W = $clog2(LDEPTH);
  localparam int COEF_N  = MAX_KERNEL * MAX_KERNEL;
  localparam int CADDR_W = $clog2(COEF_N);
  localparam int KER_W   = $clog2(MAX_KERNEL + 1);
  localparam int PIX_W   = 16;
  localparam int PROD_W  = 33;
  localparam int ACC_W   = 38;
  localparam int FRAC_SH = 14;
  localparam int RES_W   = ACC_W - FRAC_SH;
  localparam int DIST_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int LAG_W   = $clog2(MAX_KERNEL * MAX_WIDTH + MAX_KERNEL) + 1;

  localparam logic [PIX_W-1:0] PIX_MAX = 16'h8000;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 38'sd8192;

  // opcodes of an input word
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KW     = 3'd2;
  localparam logic [2:0] REG_KH     = 3'd3;
  localparam logic [2:0] REG_ANCHOR = 3'd4;
  localparam logic [2:0] REG_BORDER = 3'd5;

  typedef struct packed {
    logic [10:0]      width;
    logic [12:0]      height;
    logic [KER_W-1:0] kw;
    logic [KER_W-1:0] kh;
    logic             mode;
    logic [PIX_W-1:0] border;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic               we;
    logic [LADDR_W-1:0] addr;
    logic [PIX_W-1:0]   data;
  } line_wr_t;

  typedef struct packed {
    logic               we;
    logic [CADDR_W-1:0] addr;
    logic [PIX_W-1:0]   data;
  } coef_wr_t;

  typedef struct packed {
    logic             busy;
    logic [ROW_W-1:0] row;
    logic             tail_done;
  } back_stat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH,
    BK_OUT
  } bk_state_t;

  // window origin offsets: rows above and columns left of the output position
  function automatic logic [KER_W-1:0] win_offr(cfg_t c);
    logic [KER_W-1:0] km1;
    km1 = c.kh - 1'b1;
    return c.mode ? '0 : (km1 >> 1);
  endfunction

  function automatic logic [KER_W-1:0] win_offc(cfg_t c);
    logic [KER_W-1:0] km1;
    km1 = c.kw - 1'b1;
    return c.mode ? km1 : (km1 >> 1);
  endfunction

endpackage

// ----- design/wcv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wcv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- design/wcv_front.sv -----
// Front end: accepts words, writes line store and coefficient table, tracks
// raster counters and issues output jobs. Depends on wcv_pkg.
module wcv_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wcv_pkg::cfg_t            cfg,
  input  logic                     geo_clr,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               opcode,
  input  logic [5:0]               coeff_index,
  input  logic signed [15:0]       coeff_value,
  input  logic [15:0]              pixel,
  input  logic                     jq_full,
  input  logic                     pending,
  input  logic [wcv_pkg::ROW_W-1:0] pend_row,
  input  wcv_pkg::back_stat_t      bstat,
  output wcv_pkg::line_wr_t        lwr,
  output wcv_pkg::coef_wr_t        cwr,
  output logic                     job_push,
  output wcv_pkg::job_t            job
);
  import wcv_pkg::*;

  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic              done_r, done_nxt, tail_r, tail_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt, dist_inc;

  logic [COL_W:0]    col_inc, ocol_inc;
  logic [ROW_W:0]    row_inc, orow_inc;
  logic              col_wrap, frm_wrap, ocol_wrap, orow_wrap;
  logic [KER_W-1:0]  dr, dc;
  logic [LAG_W-1:0]  lag;
  logic              is_load, is_pix, is_drain, take, emit, pend_block;

  assign is_load  = (opcode == OP_LOAD);
  assign is_pix   = (opcode == OP_PIXEL);
  assign is_drain = (opcode == OP_DRAIN);

  assign col_inc  = {1'b0, in_col_r} + 1'b1;
  assign row_inc  = {1'b0, in_row_r} + 1'b1;
  assign col_wrap = col_inc >= cfg.width;
  assign frm_wrap = col_wrap && (row_inc >= cfg.height);

  assign ocol_inc  = {1'b0, out_col_r} + 1'b1;
  assign orow_inc  = {1'b0, out_row_r} + 1'b1;
  assign ocol_wrap = ocol_inc >= cfg.width;
  assign orow_wrap = ocol_wrap && (orow_inc >= cfg.height);

  // raster distance between an output and the input that releases it
  assign dr  = cfg.mode ? (cfg.kh - 1'b1) : (cfg.kh >> 1);
  assign dc  = cfg.mode ? '0 : (cfg.kw >> 1);
  assign lag = LAG_W'(dr) * LAG_W'(cfg.width) + LAG_W'(dc);
  assign dist_inc = dist_r + 1'b1;

  // a new pixel must not overwrite a store row that a pending job still reads
  assign pend_block = pending &&
    (({1'b0, in_row_r} + (ROW_W+1)'(win_offr(cfg))) >=
     ({1'b0, pend_row} + (ROW_W+1)'(STORE_ROWS)));

  always_comb begin
    case (opcode)
      OP_LOAD:  full = pending;
      OP_PIXEL: full = !done_r && (jq_full || tail_r || pend_block);
      OP_DRAIN: full = done_r && jq_full;
      default:  full = 1'b0;
    endcase
  end

  assign take = push && !full;
  assign emit = take && ((is_pix && !done_r &&
                          (frm_wrap || (dist_inc > DIST_W'(lag)))) ||
                         (is_drain && done_r));

  assign lwr.we   = take && is_pix && !done_r;
  assign lwr.addr = {in_row_r[SROW_W-1:0], in_col_r};
  assign lwr.data = (pixel > PIX_MAX) ? PIX_MAX : pixel;

  assign cwr.we   = take && is_load && (coeff_index < CADDR_W'(COEF_N));
  assign cwr.addr = coeff_index;
  assign cwr.data = coeff_value;

  assign job_push = emit;
  assign job.row  = out_row_r;
  assign job.col  = out_col_r;
  assign job.last = orow_wrap;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    done_nxt    = done_r;
    dist_nxt    = dist_r;
    tail_nxt    = tail_r;
    if (geo_clr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      done_nxt    = 1'b0;
      dist_nxt    = '0;
      tail_nxt    = 1'b0;
    end else begin
      if (bstat.tail_done) begin
        tail_nxt = 1'b0;
      end
      if (lwr.we) begin
        dist_nxt = dist_inc;
        if (col_wrap) begin
          in_col_nxt = '0;
          if (frm_wrap) begin
            in_row_nxt = '0;
            done_nxt   = 1'b1;
          end else begin
            in_row_nxt = row_inc[ROW_W-1:0];
          end
        end else begin
          in_col_nxt = col_inc[COL_W-1:0];
        end
      end
      if (emit) begin
        dist_nxt = dist_nxt - 1'b1;
        if (ocol_wrap) begin
          out_col_nxt = '0;
          if (orow_wrap) begin
            // frame complete: start over
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_row_nxt = '0;
            done_nxt    = 1'b0;
            dist_nxt    = '0;
            tail_nxt    = 1'b1;
          end else begin
            out_row_nxt = orow_inc[ROW_W-1:0];
          end
        end else begin
          out_col_nxt = ocol_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
      dist_r    <= '0;
      tail_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      done_r    <= done_nxt;
      dist_r    <= dist_nxt;
      tail_r    <= tail_nxt;
    end
  end

endmodule

// ----- design/wcv_back.sv -----
// Back end: walks the kernel window of one job, one tap per cycle, through a
// shared multiplier and accumulator. Depends on wcv_pkg.
module wcv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wcv_pkg::cfg_t               cfg,
  input  logic                        job_valid,
  input  wcv_pkg::job_t               job,
  output logic                        job_take,
  output logic [wcv_pkg::LADDR_W-1:0] line_raddr,
  input  logic [wcv_pkg::PIX_W-1:0]   line_rdata,
  output logic [wcv_pkg::CADDR_W-1:0] coef_raddr,
  input  logic [wcv_pkg::PIX_W-1:0]   coef_rdata,
  input  logic                        out_space,
  output logic                        res_push,
  output wcv_pkg::res_t               res,
  output wcv_pkg::back_stat_t         bstat
);
  import wcv_pkg::*;

  bk_state_t state_r, state_nxt;
  job_t      job_r;
  logic [KER_W-1:0] i_r, j_r;
  logic      s1_v_r, s1_bord_r, s2_v_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, sum;
  logic      issue, last_tap, border;
  logic signed [ROW_W+1:0] row_s;
  logic signed [COL_W+1:0] col_s;
  logic [PIX_W-1:0] val;

  assign last_tap = (i_r == cfg.kh - 1'b1) && (j_r == cfg.kw - 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (job_valid) state_nxt = BK_RUN;
      BK_RUN:   if (last_tap) state_nxt = BK_FLUSH;
      BK_FLUSH: if (!s1_v_r && !s2_v_r) state_nxt = BK_OUT;
      BK_OUT:   if (out_space) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_take = 1'b0;
    issue    = 1'b0;
    res_push = 1'b0;
    case (state_r)
      BK_IDLE: job_take = job_valid;
      BK_RUN:  issue    = 1'b1;
      BK_OUT:  res_push = out_space;
      default: ;
    endcase
  end

  // tap position in the frame
  assign row_s = $signed((ROW_W+2)'(job_r.row)) + $signed((ROW_W+2)'(i_r))
               - $signed((ROW_W+2)'(win_offr(cfg)));
  assign col_s = $signed((COL_W+2)'(job_r.col)) + $signed((COL_W+2)'(j_r))
               - $signed((COL_W+2)'(win_offc(cfg)));
  assign border = (row_s < 0) || (row_s >= $signed((ROW_W+2)'(cfg.height))) ||
                  (col_s < 0) || (col_s >= $signed((COL_W+2)'(cfg.width)));

  assign line_raddr = {row_s[SROW_W-1:0], col_s[COL_W-1:0]};
  assign coef_raddr = CADDR_W'(i_r) * CADDR_W'(MAX_KERNEL) + CADDR_W'(j_r);

  assign val      = s1_bord_r ? cfg.border : line_rdata;
  assign prod_nxt = $signed({1'b0, val}) * $signed(coef_rdata);

  // round half up to Q8.15
  assign sum       = acc_r + ROUND_BIAS;
  assign res.value = sum[ACC_W-1:FRAC_SH];
  assign res.last  = job_r.last;

  assign bstat.busy      = (state_r != BK_IDLE);
  assign bstat.row       = job_r.row;
  assign bstat.tail_done = res_push && job_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (job_take) begin
        i_r <= '0;
        j_r <= '0;
      end else if (issue) begin
        if (j_r == cfg.kw - 1'b1) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_bord_r <= border;
    prod_r    <= prod_nxt;
    if (job_take) begin
      job_r <= job;
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

endmodule

// ----- design/window_convolution_2d.sv -----
// Top level of the 2D sliding-window convolution block: config registers,
// job and result queues, line store and coefficient RAMs. Uses wcv_pkg,
// wcv_ram, wcv_front and wcv_back.
//
// Usage: words enter through push/full. A load word writes one coefficient,
// a pixel word enters the raster frame, a drain word flushes one output once
// the frame's pixels are all in. Results leave through empty/pop, oldest
// first; last_of_frame marks the frame's final output pixel.
// Throughput: the back end reads one window tap per cycle from the line
// store port and feeds one multiplier. A two-entry job queue lets the front
// keep taking words while a window is computed.
// The front holds a word (full high) when the job queue is full, when a
// coefficient load arrives with windows still pending, when a pixel would
// overwrite a line-store row that a pending window still reads, or when a
// pixel comes before the last result of the previous frame is queued.
// When pop stays low, the result queue (two words) fills, the back end holds
// its finished sum, and then the job queue and front back up in turn.
// Reset: counters cleared, registers at their defaults, queues empty. The
// coefficients hold no value until loaded. Geometry writes abandon the frame.
module window_convolution_2d (
  input  logic               clk,
  input  logic               rst_n,
  // word input
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_coeff_index,
  input  logic signed [15:0] in_coeff_value,
  input  logic [15:0]        in_pixel,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] out_result_value,
  output logic               out_last_of_frame,
  // APB config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wcv_pkg::*;

  // ---------------- config registers ----------------
  cfg_t       cfg_r;
  logic       cfg_wr, geo_clr;
  logic [2:0] reg_idx;
  logic [10:0] w_in;
  logic [12:0] h_in;
  logic [KER_W-1:0] kw_in, kh_in;
  logic [15:0] b_in;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign geo_clr = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                              reg_idx == REG_KW || reg_idx == REG_KH ||
                              reg_idx == REG_ANCHOR);

  assign w_in  = pwdata[10:0];
  assign h_in  = pwdata[12:0];
  assign kw_in = pwdata[KER_W-1:0];
  assign kh_in = pwdata[KER_W-1:0];
  assign b_in  = pwdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 11'd256;
      cfg_r.height <= 13'd256;
      cfg_r.kw     <= KER_W'(3);
      cfg_r.kh     <= KER_W'(3);
      cfg_r.mode   <= 1'b0;
      cfg_r.border <= PIX_MAX;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  cfg_r.width  <= (w_in == '0) ? 11'd1 :
                                    (w_in > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : w_in;
        REG_HEIGHT: cfg_r.height <= (h_in == '0) ? 13'd1 :
                                    (h_in > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : h_in;
        REG_KW:     cfg_r.kw     <= (kw_in == '0) ? KER_W'(1) : kw_in;
        REG_KH:     cfg_r.kh     <= (kh_in == '0) ? KER_W'(1) : kh_in;
        REG_ANCHOR: cfg_r.mode   <= pwdata[0];
        REG_BORDER: cfg_r.border <= (b_in > PIX_MAX) ? PIX_MAX : b_in;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(cfg_r.width);
      REG_HEIGHT: prdata = 32'(cfg_r.height);
      REG_KW:     prdata = 32'(cfg_r.kw);
      REG_KH:     prdata = 32'(cfg_r.kh);
      REG_ANCHOR: prdata = 32'(cfg_r.mode);
      REG_BORDER: prdata = 32'(cfg_r.border);
      default:    prdata = '0;
    endcase
  end

  // ---------------- front / back ----------------
  line_wr_t   lwr;
  coef_wr_t   cwr;
  back_stat_t bstat;
  job_t       job_in, jq_head;
  logic       job_push, job_take, jq_full, pending;
  logic [ROW_W-1:0] pend_row;
  logic [LADDR_W-1:0] line_raddr;
  logic [CADDR_W-1:0] coef_raddr;
  logic [PIX_W-1:0]   line_rdata, coef_rdata;
  logic       res_push, out_space;
  res_t       res;

  // job queue, two entries
  job_t       jq_mem_r [2];
  logic       jq_wp_r, jq_rp_r;
  logic [1:0] jq_cnt_r;

  assign jq_full  = (jq_cnt_r == 2'd2);
  assign jq_head  = jq_mem_r[jq_rp_r];
  assign pending  = bstat.busy || (jq_cnt_r != 2'd0);
  assign pend_row = bstat.busy ? bstat.row : jq_head.row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jq_wp_r  <= 1'b0;
      jq_rp_r  <= 1'b0;
      jq_cnt_r <= '0;
    end else begin
      if (job_push) jq_wp_r <= ~jq_wp_r;
      if (job_take) jq_rp_r <= ~jq_rp_r;
      jq_cnt_r <= jq_cnt_r + {1'b0, job_push} - {1'b0, job_take};
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) jq_mem_r[jq_wp_r] <= job_in;
  end

  wcv_front u_front (
    .clk, .rst_n,
    .cfg         (cfg_r),
    .geo_clr,
    .push,
    .full,
    .opcode      (in_opcode),
    .coeff_index (in_coeff_index),
    .coeff_value (in_coeff_value),
    .pixel       (in_pixel),
    .jq_full,
    .pending,
    .pend_row,
    .bstat,
    .lwr,
    .cwr,
    .job_push,
    .job         (job_in)
  );

  wcv_ram #(.WIDTH(PIX_W), .DEPTH(LDEPTH)) u_line_ram (
    .clk,
    .we    (lwr.we),
    .waddr (lwr.addr),
    .wdata (lwr.data),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  wcv_ram #(.WIDTH(PIX_W), .DEPTH(COEF_N)) u_coef_ram (
    .clk,
    .we    (cwr.we),
    .waddr (cwr.addr),
    .wdata (cwr.data),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  wcv_back u_back (
    .clk, .rst_n,
    .cfg        (cfg_r),
    .job_valid  (jq_cnt_r != 2'd0),
    .job        (jq_head),
    .job_take,
    .line_raddr,
    .line_rdata,
    .coef_raddr,
    .coef_rdata,
    .out_space,
    .res_push,
    .res,
    .bstat
  );

  // ---------------- result queue, two words ----------------
  res_t       oq_mem_r [2];
  logic       oq_wp_r, oq_rp_r, oq_pop;
  logic [1:0] oq_cnt_r;

  assign out_space = (oq_cnt_r != 2'd2);
  assign empty     = (oq_cnt_r == 2'd0);
  assign oq_pop    = pop && !empty;
  assign out_result_value  = oq_mem_r[oq_rp_r].value;
  assign out_last_of_frame = oq_mem_r[oq_rp_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (res_push) oq_wp_r <= ~oq_wp_r;
      if (oq_pop)   oq_rp_r <= ~oq_rp_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, res_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) oq_mem_r[oq_wp_r] <= res;
  end

  // ---------------- checks ----------------
  a_jq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    jq_full |-> !job_push)
    else $error("job queue overflow");

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_cnt_r == 2'd2) |-> !res_push)
    else $error("result queue overflow");

  a_coef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cwr.we |-> (!bstat.busy && (jq_cnt_r == 2'd0)))
    else $error("coefficient written while a window is pending");

  a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (jq_cnt_r != 2'd0))
    else $error("back end took a job from an empty queue");

endmodule
